FILE: rtl/tdpt_pkg.sv
// ---------------------------------------------------------------------------
// tdpt_pkg - shared types and constants for the trial division prime test
// Holds the default operand width and the sequencer state type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdpt_pkg;

  // default width of the tested value
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_START = 2'd1,
    ST_RUN   = 2'd2,
    ST_DONE  = 2'd3
  } tdpt_state_e;

endpackage

FILE: rtl/tdpt_div.sv
// ---------------------------------------------------------------------------
// tdpt_div - iterative unsigned divider
// Restoring shift-subtract divider, one quotient bit per cycle. Gives
// quotient and remainder with a done pulse after the last step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdpt_div
  import tdpt_pkg::*;
#(
  parameter int unsigned W = VALUE_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W:0]       rem_q;
  logic [W-1:0]     quot_q;
  logic [W-1:0]     dvs_q;

  logic [W:0]       rem_sh;
  logic [W:0]       rem_diff;
  logic             rem_ge;

  // one shift-subtract step
  always_comb begin
    rem_sh   = {rem_q[W-1:0], quot_q[W-1]};
    rem_ge   = (rem_sh >= {1'b0, dvs_q});
    rem_diff = rem_sh - {1'b0, dvs_q};
  end

  // control: busy flag, bit counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // datapath: partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_ge ? rem_diff : rem_sh;
      quot_q <= {quot_q[W-2:0], rem_ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  // remainder is below the divisor, so the top bit is always zero
  assign rem_o  = rem_q[W-1:0];

  // a new division is only started on an idle unit
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  // done follows the last step, never a running division
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  // done comes in the cycle right after the last step
  a_done_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (cnt_q == '0) && !start_i) |=> done_q)
    else $error("divider missed done pulse");

endmodule

FILE: rtl/trial_division_prime_test.sv
// ---------------------------------------------------------------------------
// trial_division_prime_test - primality test by trial division
// Tests one signed value per transfer. Divisors run from 2 upward while
// d*d <= v (checked as d <= v/d); a zero remainder means not prime.
//
// channel   direction  tdata fields (lsb first)       tuser  tlast
// s_axis    in         test_value [VALUE_WIDTH-1:0]   -      -
// m_axis    out        is_prime [0], zero padding     -      -
//
// values that are negative, zero or one skip the divider; otherwise
//   each trial divisor takes one pass through the shared divider, about
//   sqrt(v) divisors for a prime v (worst case near 46341 divisors at
//   32 bits)
// s_axis_tready_o is high only while the sequencer is idle
// one result register decouples the output; a stalled result holds the
//   finished next result in the done state until taken
// reset is asynchronous, active low, and returns the sequencer to idle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int unsigned TDATA_W    = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,  // [VALUE_WIDTH-1:0] test_value, rest ignored
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [7:0]         m_axis_tdata_o   // [0] is_prime, [7:1] zero
);

  localparam int unsigned W = VALUE_WIDTH;

  tdpt_state_e state_q, state_d;

  logic [W-1:0] v_q;
  logic [W-1:0] d_q;
  logic         res_q;
  logic         out_valid_q;
  logic         out_bit_q;

  logic [W-1:0] raw;
  logic         accept;
  logic         trivial;
  logic         out_free;
  logic         div_start;
  logic         div_done;
  logic [W-1:0] div_quot;
  logic [W-1:0] div_rem;
  logic         bound_hit;
  logic         factor_hit;
  logic         out_load;

  // input decode
  always_comb begin
    raw        = s_axis_tdata_i[W-1:0];
    accept     = s_axis_tvalid_i && s_axis_tready_o;
    trivial    = raw[W-1] || (raw <= W'(1));
    out_free   = !out_valid_q || m_axis_tready_i;
    bound_hit  = div_quot < d_q;
    factor_hit = (div_rem == '0);
  end

  // shared divider: v / d for the current trial divisor
  tdpt_div #(
    .W (W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (v_q),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = trivial ? ST_DONE : ST_START;
        end
      end
      ST_START: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (div_done) begin
          state_d = (bound_hit || factor_hit) ? ST_DONE : ST_START;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      ST_IDLE:  s_axis_tready_o = 1'b1;
      ST_START: div_start       = 1'b1;
      ST_RUN:   ;
      ST_DONE:  out_load        = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // value, trial divisor and verdict
  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q   <= raw;
      d_q   <= W'(2);
      res_q <= 1'b0;
    end else if ((state_q == ST_RUN) && div_done) begin
      if (bound_hit) begin
        res_q <= 1'b1;
      end else if (factor_hit) begin
        res_q <= 1'b0;
      end else begin
        d_q <= d_q + W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bit_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_bit_q};

  // an accepted value always leaves idle
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("sequencer stayed idle after accepting a value");

  // divider results only arrive while the sequencer waits for them
  a_done_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_RUN))
    else $error("divider finished outside the run state");

  // trial divisor never falls below two
  a_divisor_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (d_q >= W'(2)))
    else $error("trial divisor below two");

  // a prime verdict only follows a divider pass that reached the bound
  a_prime_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && div_done && !bound_hit && factor_hit) |=> !res_q)
    else $error("factor found but verdict set to prime");

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top - testbench for trial_division_prime_test
// Streams signed test values into the block and checks every is_prime
// result, in order, against a trial-division predictor kept in the bench.
// Covers fixed corner values, random values under several idle patterns
// and a long output hold-off that backs the block up into its input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import tdpt_pkg::*;
;

  localparam int unsigned VW         = VALUE_WIDTH_DEF;
  localparam int unsigned TDW        = ((VW + 7) / 8) * 8;
  localparam int unsigned HOLD_LEN   = 3000;
  localparam int unsigned DRAIN_WAIT = 200;

  // one expected verdict per accepted test value
  typedef struct packed {
    logic [VW-1:0] value;
    logic          is_prime;
  } verdict_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [TDW-1:0] s_axis_tdata = '0;   // [VW-1:0] test_value
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [7:0]     m_axis_tdata;        // [0] is_prime, [7:1] zero padding

  verdict_t verdict_q[$];
  int unsigned n_errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_rx = 1'b0;

  trial_division_prime_test #(
    .VALUE_WIDTH(VW)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // trial division on the value read as signed
  function automatic logic predict_is_prime(input logic [VW-1:0] raw);
    longint unsigned v;
    longint unsigned d;
    v = raw;
    if (raw[VW-1]) return 1'b0;
    if (v <= 1) return 1'b0;
    for (d = 2; d <= v / d; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // random value, mostly cheap to test: small, negative, or with a small factor
  function automatic logic [VW-1:0] rand_test_value();
    int unsigned sel;
    logic [VW-1:0] x;
    sel = $urandom_range(99);
    x = $urandom;
    if (sel < 35) begin
      x = $urandom_range(1023);
    end else if (sel < 60) begin
      x = $urandom_range(65535);
    end else if (sel < 75) begin
      x[VW-1] = 1'b1;
    end else if (sel < 88) begin
      x[VW-1] = 1'b0;
      x[0] = 1'b0;
    end else if (sel < 95) begin
      x[VW-1] = 1'b0;
      x = x - (x % 3);
    end else begin
      x = $urandom_range(2);
    end
    return x;
  endfunction

  // offer one test value; starts and returns at a falling edge
  task automatic send_value(input logic [VW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDW'(v);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    verdict_q.push_back('{value: v, is_prime: predict_is_prime(v)});
    @(negedge clk_i);
  endtask

  // receiver ready, with random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (hold_rx) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long hold-off, counted in cycles
  always begin
    wait (hold_req);
    hold_rx <= 1'b1;
    repeat (HOLD_LEN) @(negedge clk_i);
    hold_rx <= 1'b0;
    wait (!hold_req);
  end

  // compare each result transfer with the oldest verdict
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result transfer, tdata %h", m_axis_tdata);
        n_errors++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (m_axis_tdata[0] !== exp_v.is_prime) begin
          $error("is_prime for %0d: expected %0d, actual %0d",
                 $signed(exp_v.value), exp_v.is_prime, m_axis_tdata[0]);
          n_errors++;
        end
        if (m_axis_tdata[7:1] !== 7'd0) begin
          $error("padding for %0d: expected 0, actual %h",
                 $signed(exp_v.value), m_axis_tdata[7:1]);
          n_errors++;
        end
      end
    end
  end

  // corner values: signs, zero, one, small primes, square boundaries
  task automatic test_directed_values();
    logic [VW-1:0] vals[$];
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    vals = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
             32'd97, 32'd1018081, 32'd1022117, 32'd1000003, 32'd16777213,
             32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'h7FFF_FFFE,
             32'h7FFF_FFFD, 32'h5555_5555, 32'h2AAA_AAAA, 32'h7FFF_0000};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // random values under one idle pattern
  task automatic test_random_values(input int unsigned s_pct,
                                    input int unsigned r_pct,
                                    input int unsigned count);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (count) send_value(rand_test_value());
  endtask

  // output held off long enough that the block stops taking input
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    repeat (8) send_value(rand_test_value() | {1'b1, {(VW-1){1'b0}}});
    hold_req = 1'b0;
  endtask

  // stimulus sequence
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_values();
    test_random_values(0, 0, 18);
    test_random_values(54, 0, 18);
    test_random_values(0, 54, 18);
    test_random_values(15, 15, 18);
    test_output_backpressure();
    s_axis_tvalid <= 1'b0;
    recv_stall_pct = 0;
    wait (verdict_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #80_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/tdpt_pkg.sv
rtl/tdpt_div.sv
rtl/trial_division_prime_test.sv
tb/tb_top.sv
